@@ design/urls_pkg.sv @@
// ----------------------------------------------------------------------------
// urls_pkg
// Shared types and codes for the ultrasonic ranging and line steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package urls_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] REG_NEAR_LIMIT   = 2'd0;
   localparam logic [1:0] REG_REST_PERIOD  = 2'd1;
   localparam logic [1:0] REG_ECHO_TIMEOUT = 2'd2;
   localparam logic [1:0] REG_MM_PER_US    = 2'd3;

   localparam logic [15:0] NEAR_LIMIT_RESET   = 16'd400;
   localparam logic [19:0] REST_PERIOD_RESET  = 20'd500000;
   localparam logic [15:0] ECHO_TIMEOUT_RESET = 16'd38000;
   localparam logic [15:0] MM_PER_US_RESET    = 16'd11239;

   // ranging phases
   localparam logic [2:0] PH_TRIG_LOW  = 3'd0;
   localparam logic [2:0] PH_TRIG_HIGH = 3'd1;
   localparam logic [2:0] PH_WAIT      = 3'd2;
   localparam logic [2:0] PH_MEASURE   = 3'd3;
   localparam logic [2:0] PH_REST      = 3'd4;

   // steering states
   localparam logic [2:0] ST_STRAIGHT    = 3'd0;
   localparam logic [2:0] ST_LEFT        = 3'd1;
   localparam logic [2:0] ST_RIGHT       = 3'd2;
   localparam logic [2:0] ST_PIVOT_LEFT  = 3'd3;
   localparam logic [2:0] ST_PIVOT_RIGHT = 3'd4;
   localparam logic [2:0] ST_OFFROAD     = 3'd5;

   // line patterns, left center right
   localparam logic [2:0] PAT_LEFT        = 3'b100;
   localparam logic [2:0] PAT_RIGHT       = 3'b001;
   localparam logic [2:0] PAT_PIVOT_LEFT  = 3'b110;
   localparam logic [2:0] PAT_PIVOT_RIGHT = 3'b011;
   localparam logic [2:0] PAT_STRAIGHT    = 3'b010;

   localparam int unsigned TRIG_LOW_TICKS  = 2;
   localparam int unsigned TRIG_HIGH_TICKS = 10;

   localparam logic [15:0] DISTANCE_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] near_limit_mm;
      logic [19:0] rest_period_us;
      logic [15:0] echo_timeout_us;
      logic [15:0] mm_per_us_q16;
   } cfg_type;

   typedef struct packed {
      logic echo;
      logic track_l;
      logic track_c;
      logic track_r;
      logic resume;
   } req_type;

   typedef struct packed {
      logic        trigger;
      logic [2:0]  steer_state;
      logic        distance_valid;
      logic [15:0] distance_mm;
      logic        echo_timeout;
      logic        line_hit;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/urls_csr.sv @@
// ----------------------------------------------------------------------------
// urls_csr
// Configuration registers behind an APB-style write and read port.
// ----------------------------------------------------------------------------
`default_nettype none

module urls_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   output urls_pkg::cfg_type       cfg
);
   import urls_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NEAR_LIMIT:   cfg_in.near_limit_mm   = pwdata[15:0];
            REG_REST_PERIOD:  cfg_in.rest_period_us  = pwdata[19:0];
            REG_ECHO_TIMEOUT: cfg_in.echo_timeout_us = pwdata[15:0];
            REG_MM_PER_US:    cfg_in.mm_per_us_q16   = pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit_mm   <= NEAR_LIMIT_RESET;
         cfg_ff.rest_period_us  <= REST_PERIOD_RESET;
         cfg_ff.echo_timeout_us <= ECHO_TIMEOUT_RESET;
         cfg_ff.mm_per_us_q16   <= MM_PER_US_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NEAR_LIMIT:   prdata = {16'd0, cfg_ff.near_limit_mm};
         REG_REST_PERIOD:  prdata = {12'd0, cfg_ff.rest_period_us};
         REG_ECHO_TIMEOUT: prdata = {16'd0, cfg_ff.echo_timeout_us};
         REG_MM_PER_US:    prdata = {16'd0, cfg_ff.mm_per_us_q16};
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ design/urls_core.sv @@
// ----------------------------------------------------------------------------
// urls_core
// Ranging sequencer and steering state, advanced by one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module urls_core #(
   parameter int unsigned ECHO_COUNT_BITS   = 16,
   parameter int unsigned PERIOD_COUNT_BITS = 20
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  urls_pkg::cfg_type       cfg,
   input  urls_pkg::req_type       req,
   output urls_pkg::rsp_type       rsp
);
   import urls_pkg::*;

   localparam int unsigned EW = ECHO_COUNT_BITS;
   localparam int unsigned PW = PERIOD_COUNT_BITS;
   localparam int unsigned LW = (PW > 20) ? PW : 20;
   localparam int unsigned DW = (EW > 16) ? EW : 16;
   localparam logic [PW-1:0] CNT_MAX   = {PW{1'b1}};
   localparam logic [EW-1:0] WIDTH_MAX = {EW{1'b1}};

   logic [2:0]    phase_ff, phase_in;
   logic [PW-1:0] count_ff, count_in;
   logic [EW-1:0] width_ff, width_in;
   logic [15:0]   held_ff, held_in;
   logic [2:0]    mode_ff, mode_in;
   logic          flag_ff, flag_in;

   logic [EW+15:0] product;
   logic [DW-1:0]  dist_wide;
   logic [15:0]    range_mm;
   logic [PW-1:0]  count_inc;
   logic [PW-1:0]  timeout_ext;
   logic [LW-1:0]  rest_limit;
   logic [2:0]     pattern;
   logic           dist_valid;
   logic           timed_out;

   assign product   = (EW+16)'(width_ff) * (EW+16)'(cfg.mm_per_us_q16);
   assign dist_wide = DW'(product >> 16);
   assign range_mm  = (dist_wide > DW'(DISTANCE_MAX)) ? DISTANCE_MAX : dist_wide[15:0];

   assign count_inc   = (count_ff == CNT_MAX) ? count_ff : count_ff + PW'(1);
   assign timeout_ext = PW'(cfg.echo_timeout_us);
   // rest period clipped to what the phase counter can reach
   assign rest_limit  = (LW'(cfg.rest_period_us) < LW'(CNT_MAX)) ?
                        LW'(cfg.rest_period_us) : LW'(CNT_MAX);
   assign pattern     = {req.track_l, req.track_c, req.track_r};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      width_in   = width_ff;
      held_in    = held_ff;
      mode_in    = mode_ff;
      flag_in    = flag_ff;
      dist_valid = 1'b0;
      timed_out  = 1'b0;

      // resume acts before the ranging step
      if (req.resume) begin
         flag_in = 1'b0;
         if (mode_ff == ST_OFFROAD) begin
            mode_in = ST_STRAIGHT;
         end
      end

      unique case (phase_ff)
         PH_TRIG_LOW: begin
            count_in = count_inc;
            if (count_inc >= PW'(TRIG_LOW_TICKS)) begin
               phase_in = PH_TRIG_HIGH;
               count_in = '0;
            end
         end
         PH_TRIG_HIGH: begin
            count_in = count_inc;
            if (count_inc >= PW'(TRIG_HIGH_TICKS)) begin
               phase_in = PH_WAIT;
               count_in = '0;
            end
         end
         PH_WAIT: begin
            if (req.echo) begin
               phase_in = PH_MEASURE;
               count_in = PW'(1);
               width_in = EW'(1);
            end else begin
               count_in = count_inc;
            end
            if (count_in >= timeout_ext) begin
               timed_out = 1'b1;
               phase_in  = PH_REST;
               count_in  = '0;
            end
         end
         PH_MEASURE: begin
            if (req.echo) begin
               count_in = count_inc;
               width_in = (width_ff == WIDTH_MAX) ? width_ff : width_ff + EW'(1);
               if (count_inc >= timeout_ext) begin
                  timed_out = 1'b1;
                  phase_in  = PH_REST;
                  count_in  = '0;
               end
            end else begin
               held_in    = range_mm;
               dist_valid = 1'b1;
               if (range_mm < cfg.near_limit_mm) begin
                  mode_in = ST_OFFROAD;
               end
               phase_in = PH_REST;
               count_in = '0;
            end
         end
         default: begin
            count_in = count_inc;
            if (LW'(count_inc) >= rest_limit) begin
               phase_in = PH_TRIG_LOW;
               count_in = '0;
            end
         end
      endcase

      if (mode_in != ST_OFFROAD) begin
         unique case (pattern)
            PAT_LEFT:        mode_in = ST_LEFT;
            PAT_RIGHT:       mode_in = ST_RIGHT;
            PAT_PIVOT_LEFT:  mode_in = ST_PIVOT_LEFT;
            PAT_PIVOT_RIGHT: mode_in = ST_PIVOT_RIGHT;
            PAT_STRAIGHT:    mode_in = ST_STRAIGHT;
            default:         ;
         endcase
      end else if (|pattern) begin
         flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIG_LOW;
         count_ff <= '0;
         width_ff <= '0;
         held_ff  <= DISTANCE_MAX;
         mode_ff  <= ST_STRAIGHT;
         flag_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         width_ff <= width_in;
         held_ff  <= held_in;
         mode_ff  <= mode_in;
         flag_ff  <= flag_in;
      end
   end

   always_comb begin
      rsp.trigger        = (phase_ff == PH_TRIG_HIGH);
      rsp.steer_state    = mode_in;
      rsp.distance_valid = dist_valid;
      rsp.distance_mm    = held_in;
      rsp.echo_timeout   = timed_out;
      rsp.line_hit       = flag_in;
   end

endmodule

`default_nettype wire

@@ design/ultrasonic_range_line_steer.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_range_line_steer
// Ultrasonic ranging controller with line sensor steering, one tick per word.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  echo, track_l/c/r, resume
//   rsp       out         rsp_valid / rsp_stall  trigger, steer_state, distance, flags
//   csr       in          psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// A tick word passes an input register, then a result register, one word per
// cycle sustained while rsp_stall is low. The ranging state advances as the
// word leaves the input register, through one 16-by-echo-width multiply.
// Reset is synchronous and needs no clearing pass. A stalled result holds in
// the result register while one more word is taken into the input register.
//
`default_nettype none

module ultrasonic_range_line_steer #(
   parameter int unsigned ECHO_COUNT_BITS   = 16,
   parameter int unsigned PERIOD_COUNT_BITS = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_echo,
   input  wire logic        req_track_l,
   input  wire logic        req_track_c,
   input  wire logic        req_track_r,
   input  wire logic        req_resume,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_trigger,
   output logic [2:0]       rsp_steer_state,
   output logic             rsp_distance_valid,
   output logic [15:0]      rsp_distance_mm,
   output logic             rsp_echo_timeout,
   output logic             rsp_line_hit,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import urls_pkg::*;

   cfg_type cfg;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_calc;
   logic    req_valid_ff, req_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    advance;
   logic    req_take;

   urls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   urls_core #(
      .ECHO_COUNT_BITS   (ECHO_COUNT_BITS),
      .PERIOD_COUNT_BITS (PERIOD_COUNT_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cfg   (cfg),
      .req   (req_ff),
      .rsp   (rsp_calc)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign req_in = '{echo:    req_echo,
                     track_l: req_track_l,
                     track_c: req_track_c,
                     track_r: req_track_r,
                     resume:  req_resume};

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger        = rsp_ff.trigger;
   assign rsp_steer_state    = rsp_ff.steer_state;
   assign rsp_distance_valid = rsp_ff.distance_valid;
   assign rsp_distance_mm    = rsp_ff.distance_mm;
   assign rsp_echo_timeout   = rsp_ff.echo_timeout;
   assign rsp_line_hit       = rsp_ff.line_hit;

   // a word moved on from the input register lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word missing from result register");

   // a new reading and a timeout never share one tick
   a_valid_xor_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.distance_valid && rsp_ff.echo_timeout))
      else $error("distance and timeout on the same tick");

   // steering never leaves its defined codes
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.steer_state <= ST_OFFROAD))
      else $error("steering state out of range");

   // stall only holds back a word when the input register is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff))
      else $error("stall with room in the input register");

endmodule

`default_nettype wire
